FILE: sv/abs_encoder_frame_decoder_macros.svh
// Assertion macros shared by the frame decoder RTL.
`ifndef ABS_ENCODER_FRAME_DECODER_MACROS_SVH
`define ABS_ENCODER_FRAME_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is low.
`define AEFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frame decoder assertion failed");
// Next-cycle implication, disabled while reset is low.
`define AEFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frame decoder assertion failed");
`else
`define AEFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define AEFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/aefd_pkg.sv
// Package: format and status codes, widths and the CRC-8 byte step of the frame decoder.
package aefd_pkg;

    // Sensor format codes
    localparam logic [2:0] FMT_PARITY = 3'd0;
    localparam logic [2:0] FMT_DUAL   = 3'd1;
    localparam logic [2:0] FMT_PLAIN  = 3'd2;
    localparam logic [2:0] FMT_BURST  = 3'd3;

    // Status codes
    localparam logic [1:0] ST_GOOD  = 2'd0;
    localparam logic [1:0] ST_FAIL  = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;

    // Register map (word index taken from paddr[2])
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_CPR    = 1'b1;

    // Widths and constants
    localparam int FMT_W   = 3;
    localparam int CPR_W   = 25;
    localparam int ANGLE_W = 21;
    localparam int POS_W   = 24;
    localparam int POS14_W = 14;
    localparam int PROD_W  = ANGLE_W + CPR_W;

    localparam logic [CPR_W-1:0] CPR_RESET = 25'd8192;
    localparam logic [7:0]       CRC_POLY  = 8'h07;
    localparam logic [POS_W-1:0] POS_MAX   = 24'hFF_FFFF;

    typedef logic [POS14_W-1:0] t_pos14;

    // One byte of CRC-8, MSB first, no reflection
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: sv/abs_encoder_frame_decoder.sv
// Top level: absolute-encoder frame checker and decoder, five-stage pipeline.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+------------------------------
//  request  | start, busy, i_frame[31:0]                | taken when start && !busy
//  result   | o_valid, o_position[23:0], o_status[1:0]  | one-cycle strobe, no backpressure
//  config   | psel penable pwrite paddr[2:0] pwdata     | APB write, pready tied high
//           | prdata                                    | combinational read data
//
//  One request per cycle; busy is never raised. A taken request passes through the
//  input register, two CRC byte stages, CRC byte three with the 21x25 multiply,
//  then the output select. Reset clears the stage valid bits and sets sensor_format
//  to 0 and counts_per_rev to 8192. No stalls on either side.
`include "abs_encoder_frame_decoder_macros.svh"

module abs_encoder_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_frame,
    // result channel
    output logic        o_valid,
    output logic [23:0] o_position,
    output logic [1:0]  o_status,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [aefd_pkg::FMT_W-1:0] r_format;
    logic [aefd_pkg::CPR_W-1:0] r_cpr;

    // Stage 1: input register
    logic                       r_v1;
    logic [31:0]                r_frame1;
    logic [aefd_pkg::FMT_W-1:0] r_fmt1;

    // Stage 2: first CRC byte, 16-bit checks
    logic                         r_v2;
    logic [aefd_pkg::FMT_W-1:0]   r_fmt2;
    logic [15:0]                  r_dat2;
    logic [7:0]                   r_crc2;
    logic                         r_fail2;
    aefd_pkg::t_pos14             r_pos2;
    logic [aefd_pkg::ANGLE_W-1:0] r_angle2;

    // Stage 3: second CRC byte
    logic                         r_v3;
    logic [aefd_pkg::FMT_W-1:0]   r_fmt3;
    logic [15:0]                  r_dat3;
    logic [7:0]                   r_crc3;
    logic                         r_fail3;
    aefd_pkg::t_pos14             r_pos3;
    logic [aefd_pkg::ANGLE_W-1:0] r_angle3;

    // Stage 4: third CRC byte and compare, scale multiply
    logic                        r_v4;
    logic [aefd_pkg::FMT_W-1:0]  r_fmt4;
    logic                        r_crc_ok4;
    logic                        r_fail4;
    aefd_pkg::t_pos14            r_pos4;
    logic [aefd_pkg::PROD_W-1:0] r_prod4;

    // Output stage
    logic                       r_valid;
    logic [aefd_pkg::POS_W-1:0] r_position;
    logic [1:0]                 r_status;

    logic                         cfg_wr;
    logic                         acc;
    logic [15:0]                  word1;
    logic                         n_fail2;
    aefd_pkg::t_pos14             n_pos2;
    logic [aefd_pkg::CPR_W-1:0]   scaled;
    logic [aefd_pkg::POS_W-1:0]   n_position;
    logic [1:0]                   n_status;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign acc    = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= aefd_pkg::FMT_PARITY;
            r_cpr    <= aefd_pkg::CPR_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                aefd_pkg::REG_FORMAT: r_format <= pwdata[aefd_pkg::FMT_W-1:0];
                aefd_pkg::REG_CPR:    r_cpr    <= pwdata[aefd_pkg::CPR_W-1:0];
                default:              r_format <= r_format;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[2])
            aefd_pkg::REG_FORMAT: prdata = {{(32-aefd_pkg::FMT_W){1'b0}}, r_format};
            aefd_pkg::REG_CPR:    prdata = {{(32-aefd_pkg::CPR_W){1'b0}}, r_cpr};
            default:              prdata = '0;
        endcase
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v1    <= acc;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_valid <= r_v4;
        end
    end

    // Stage 2 logic: parity checks for the 16-bit formats
    assign word1 = r_frame1[15:0];
    always_comb begin
        case (r_fmt1)
            aefd_pkg::FMT_PARITY: n_fail2 = (^word1) | word1[14];
            aefd_pkg::FMT_DUAL:   n_fail2 = ~(^(word1 & 16'h5555)) | ~(^(word1 & 16'hAAAA));
            default:              n_fail2 = 1'b0;
        endcase
        if (r_fmt1 == aefd_pkg::FMT_PLAIN) begin
            n_pos2 = word1[15:2];
        end else begin
            n_pos2 = word1[13:0];
        end
    end

    // Stage 5 logic: scale, saturate and select
    assign scaled = r_prod4[aefd_pkg::PROD_W-1:aefd_pkg::ANGLE_W];
    always_comb begin
        n_position = '0;
        n_status   = aefd_pkg::ST_GOOD;
        case (r_fmt4)
            aefd_pkg::FMT_PARITY,
            aefd_pkg::FMT_DUAL,
            aefd_pkg::FMT_PLAIN: begin
                if (r_fail4) begin
                    n_status = aefd_pkg::ST_FAIL;
                end else begin
                    n_position = {{(aefd_pkg::POS_W-aefd_pkg::POS14_W){1'b0}}, r_pos4};
                end
            end
            aefd_pkg::FMT_BURST: begin
                if (!r_crc_ok4) begin
                    n_status = aefd_pkg::ST_FAIL;
                end else if (scaled[aefd_pkg::CPR_W-1]) begin
                    n_position = aefd_pkg::POS_MAX;
                end else begin
                    n_position = scaled[aefd_pkg::POS_W-1:0];
                end
            end
            default: n_status = aefd_pkg::ST_UNSUP;
        endcase
    end

    // Payload pipeline
    always_ff @(posedge i_clk) begin
        // stage 1
        r_frame1 <= i_frame;
        r_fmt1   <= r_format;
        // stage 2
        r_fmt2   <= r_fmt1;
        r_dat2   <= r_frame1[15:0];
        r_crc2   <= aefd_pkg::crc8_byte(8'h00, r_frame1[31:24]);
        r_fail2  <= n_fail2;
        r_pos2   <= n_pos2;
        r_angle2 <= r_frame1[31:11];
        // stage 3: byte1 sits in the angle bits 12:5
        r_fmt3   <= r_fmt2;
        r_dat3   <= r_dat2;
        r_crc3   <= aefd_pkg::crc8_byte(r_crc2, {r_angle2[12:5]});
        r_fail3  <= r_fail2;
        r_pos3   <= r_pos2;
        r_angle3 <= r_angle2;
        // stage 4
        r_fmt4    <= r_fmt3;
        r_crc_ok4 <= (aefd_pkg::crc8_byte(r_crc3, r_dat3[15:8]) == r_dat3[7:0]);
        r_fail4   <= r_fail3;
        r_pos4    <= r_pos3;
        r_prod4   <= aefd_pkg::PROD_W'(r_angle3) * aefd_pkg::PROD_W'(r_cpr);
        // output
        if (r_v4) begin
            r_position <= n_position;
            r_status   <= n_status;
        end
    end

    assign o_valid    = r_valid;
    assign o_position = r_position;
    assign o_status   = r_status;

    // Assertions
    `AEFD_ASSERT_IMPL(a_latency, i_clk, i_rst_n, acc, ##5 o_valid)
    `AEFD_ASSERT_IMPL(a_zero_on_error, i_clk, i_rst_n, o_valid && (o_status != aefd_pkg::ST_GOOD), o_position == '0)
    `AEFD_ASSERT_NEXT(a_unsup, i_clk, i_rst_n, r_v4 && (r_fmt4 > aefd_pkg::FMT_BURST), o_valid && (o_status == aefd_pkg::ST_UNSUP))
    `AEFD_ASSERT_NEXT(a_plain_good, i_clk, i_rst_n, r_v4 && (r_fmt4 == aefd_pkg::FMT_PLAIN), o_status == aefd_pkg::ST_GOOD)

endmodule
